// File: rtl/rgbscan_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rgbscan_pkg;

  localparam int SLOT_COUNT = 24;
  localparam int IDX_W      = 5;
  localparam int BRIGHT_W   = 8;
  localparam int PWM_W      = 10;
  localparam int ROWS_W     = 4;
  localparam int ROW_W      = 2;
  localparam int COL_W      = 3;

  localparam logic [COL_W-1:0]    GROUP_LAST = 3'd5;
  localparam logic [COL_W-1:0]    CHANNELS   = 3'd3;
  localparam logic [ROW_W-1:0]    ROW_LAST   = 2'd3;
  localparam logic [ROW_W:0]      HALF_LEDS  = 3'd4;
  localparam logic [BRIGHT_W-1:0] GAMMA_KNEE = 8'd252;
  localparam logic [PWM_W-1:0]    GAMMA_TOP  = 10'd1010;
  localparam logic [PWM_W-1:0]    PWM_FULL   = 10'h3FF;
  localparam logic [ROWS_W-1:0]   ROW_MASK   = 4'b1111;

  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [IDX_W-1:0]    index;
    logic [BRIGHT_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [PWM_W-1:0]  pwm_compare;
    logic [ROWS_W-1:0] row_select;
    logic              shift_data;
  } out_t;

endpackage

`default_nettype wire

// File: rtl/rgbscan_gamma.sv
`timescale 1ns / 1ps
`default_nettype none

module rgbscan_gamma (
  input  wire logic [rgbscan_pkg::BRIGHT_W-1:0] bright,
  output logic      [rgbscan_pkg::PWM_W-1:0]    compare
);

  logic [2*rgbscan_pkg::BRIGHT_W-1:0] sq;
  logic [rgbscan_pkg::PWM_W-1:0]      level;

  always_comb begin
    sq = 16'(bright) * 16'(bright);
    // above the knee the curve is clamped just short of full scale
    if (bright > rgbscan_pkg::GAMMA_KNEE) begin
      level = rgbscan_pkg::GAMMA_TOP;
    end else begin
      level = sq[15:6];
    end
    compare = rgbscan_pkg::PWM_FULL - level;
  end

endmodule

`default_nettype wire

// File: rtl/multiplexed_rgb_led_scan.sv
`timescale 1ns / 1ps
`default_nettype none

// Scan sequencer for a ring of 8 RGB LEDs driven as 4 multiplexed rows.
// Input channel (in_valid/in_ready/in_data) carries two kinds of transaction:
// a write stores one brightness byte at an index (indexes above 23 are
// dropped), a tick advances the scan by one of 24 slots. Each tick gives one
// transaction on the result channel (out_valid/out_ready/out_data): the PWM
// compare for the slot, the active-low row pattern staged by the previous
// tick, and shift_data when the new slot opens a row group. Writes give none.
// The accepting edge loads the input register; a tick then loads the output
// register as it leaves the input register, which a held result can delay,
// and out_valid rises with the output register.
// Throughput: one item per cycle unless a tick waits behind a held result; the
// input and output registers each hold one item, so a new item can be taken
// while a result waits. When the receiver stalls, ticks wait in the input
// register; writes still drain past a held result.
// Reset clears the brightness store, stages an all-zero row pattern and sets
// the scan position to the last slot so the first tick visits slot 0.
module multiplexed_rgb_led_scan (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire rgbscan_pkg::in_t    in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output rgbscan_pkg::out_t        out_data
);

  logic                                  s1_valid_r;
  rgbscan_pkg::in_t                      s1_r;
  logic                                  s1_go;
  logic [rgbscan_pkg::BRIGHT_W-1:0]      store_r [rgbscan_pkg::SLOT_COUNT];
  logic [rgbscan_pkg::ROW_W-1:0]         row_r, row_nxt;
  logic [rgbscan_pkg::COL_W-1:0]         col_r, col_nxt;
  logic [rgbscan_pkg::ROWS_W-1:0]        staged_r, staged_nxt;
  logic                                  out_valid_r;
  rgbscan_pkg::out_t                     out_r, out_nxt;
  logic [rgbscan_pkg::ROW_W:0]           led;
  logic [rgbscan_pkg::COL_W-1:0]         chan;
  logic [rgbscan_pkg::IDX_W-1:0]         entry;
  logic [rgbscan_pkg::PWM_W-1:0]         compare;
  logic                                  is_tick;

  assign is_tick  = s1_r.kind == rgbscan_pkg::KIND_TICK;
  assign s1_go    = s1_valid_r && (!is_tick || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_r <= in_data;
    end
  end

  // slot mapping: first half of a row group uses led = row, second half row + 4
  always_comb begin
    if (col_r >= rgbscan_pkg::CHANNELS) begin
      led  = {1'b0, row_r} + rgbscan_pkg::HALF_LEDS;
      chan = col_r - rgbscan_pkg::CHANNELS;
    end else begin
      led  = {1'b0, row_r};
      chan = col_r;
    end
    entry = (5'(led) << 1) + 5'(led) + 5'(chan);
  end

  rgbscan_gamma u_gamma (
    .bright  (store_r[entry]),
    .compare (compare)
  );

  always_comb begin
    if (col_r == rgbscan_pkg::GROUP_LAST) begin
      col_nxt = '0;
      row_nxt = (row_r == rgbscan_pkg::ROW_LAST) ? '0 : row_r + 2'd1;
    end else begin
      col_nxt = col_r + 3'd1;
      row_nxt = row_r;
    end
    staged_nxt           = ~(4'b0001 << row_r) & rgbscan_pkg::ROW_MASK;
    out_nxt.pwm_compare  = compare;
    out_nxt.row_select   = staged_r;
    out_nxt.shift_data   = col_nxt == '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r    <= rgbscan_pkg::ROW_LAST;
      col_r    <= rgbscan_pkg::GROUP_LAST;
      staged_r <= '0;
      for (int i = 0; i < rgbscan_pkg::SLOT_COUNT; i++) begin
        store_r[i] <= '0;
      end
    end else if (s1_go) begin
      if (is_tick) begin
        row_r    <= row_nxt;
        col_r    <= col_nxt;
        staged_r <= staged_nxt;
      end else if (s1_r.index < 5'(rgbscan_pkg::SLOT_COUNT)) begin
        store_r[s1_r.index] <= s1_r.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && is_tick) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && is_tick) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // position within a row group never leaves its range
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= rgbscan_pkg::GROUP_LAST)
    else $error("scan column out of range");

  // a consumed tick always leaves a result behind
  a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && is_tick |=> out_valid_r)
    else $error("tick consumed without a result");

  // the held result belongs to the latest tick, so shift_data tracks the position
  a_shift_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.shift_data == (col_r == '0)))
    else $error("shift_data disagrees with scan position");

  // staged rows are always one-cold once a tick has gone by
  a_staged: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && is_tick |=> $countones(staged_r) == 3)
    else $error("staged row pattern is not one-cold");

endmodule

`default_nettype wire
